// ===== rtl/core/rtpc_pkg.sv =====
// ---------------------------------------------------------------------------
// rtpc_pkg
// Shared constants, types and helpers for the reflection-to-predictor
// coefficient block.
// ---------------------------------------------------------------------------
`default_nettype none

package rtpc_pkg;

  // Block configuration
  localparam int MAX_ORDER      = 64;
  localparam int RC_FRAC_BITS   = 20;
  localparam int COEF_FRAC_BITS = 16;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ORDER_W     = ADDR_W + 1;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;

  localparam logic [ORDER_W-1:0] MAX_ORDER_C = ORDER_W'(MAX_ORDER);

  // Rounding constant and rescale amounts
  localparam logic signed [PROD_W-1:0] RND_ADD = PROD_W'(64'd1 << (RC_FRAC_BITS - 1));
  localparam int SHL_AMT = (COEF_FRAC_BITS > RC_FRAC_BITS) ?
                           (COEF_FRAC_BITS - RC_FRAC_BITS) : 0;
  localparam int SHR_AMT = (COEF_FRAC_BITS > RC_FRAC_BITS) ?
                           0 : (RC_FRAC_BITS - COEF_FRAC_BITS);

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ORDER_W-1:0] order_t;
  typedef logic [DATA_W-1:0]  word_t;

  // Coefficient store port controls
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  wr_en;
    addr_t wr_addr;
  } ram_ctrl_t;

  // Multiply-round-add unit controls
  typedef struct packed {
    logic mul_en;
    logic mul_sel_a;  // 1: multiply port A data, 0: port B data
    logic add_sel_a;  // 1: add to port A data, 0: port B data
  } step_ctrl_t;

  // Rescale rc from RC_FRAC_BITS to COEF_FRAC_BITS, wrapping at 32 bits
  function automatic word_t rescale_rc(input logic signed [DATA_W-1:0] rc);
    word_t res;
    if (COEF_FRAC_BITS > RC_FRAC_BITS) begin
      res = word_t'(rc <<< SHL_AMT);
    end else begin
      res = word_t'(rc >>> SHR_AMT);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtpc_in_if.sv =====
// ---------------------------------------------------------------------------
// rtpc_in_if
// Input channel: one reflection coefficient per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rtpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rc_value;
  logic               first_of_set;

  modport source (output valid, output rc_value, output first_of_set, input ready);
  modport sink   (input valid, input rc_value, input first_of_set, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rtpc_out_if.sv =====
// ---------------------------------------------------------------------------
// rtpc_out_if
// Output channel: one negated predictor coefficient per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface rtpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_value;
  logic [5:0]         coef_index;
  logic               last_of_run;
  logic               order_overflow;

  modport source (output valid, output coef_value, output coef_index,
                  output last_of_run, output order_overflow, input ready);
  modport sink   (input valid, input coef_value, input coef_index,
                  input last_of_run, input order_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/reflection_to_predictor_coefs_top.sv =====
// ---------------------------------------------------------------------------
// reflection_to_predictor_coefs_top
// Step-up recursion from reflection coefficients to predictor coefficients.
// ---------------------------------------------------------------------------
// Usage:
//   rc_ch   carries one reflection coefficient per transfer; first_of_set
//           restarts the recursion at order zero before it is applied.
//   coef_ch returns -a[0..n] for an input at order n, index in coef_index,
//           last_of_run on a[n]. An input past MAX_ORDER is dropped and a
//           single result with order_overflow set is returned.
//   rc_ch.ready is high only when idle; one input is processed at a time.
// Sequence for an input at order n:
//   the idle state takes the transfer; each coefficient pair is read, then
//   passes through S_MUL_HI and S_MUL_LO, since the single multiplier is used
//   twice per pair and the store has one write port; a[k] is written in
//   S_MUL_LO and a[n-1-k] in S_WR_HI, which the odd middle element skips.
//   S_WR_LAST writes a[n]; then each result is read from the store, then presented.
//   Overflow results are presented in the cycle after the input transfer.
// Reset clears the order count and state machine; the store is not cleared
//   (only entries written since a restart are read).
// A stalled receiver holds the current result; the sequence simply pauses.
// ---------------------------------------------------------------------------
`default_nettype none

module reflection_to_predictor_coefs_top
  import rtpc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  rtpc_in_if.sink     rc_ch,
  rtpc_out_if.source  coef_ch
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_READ     = 9'b000000010,
    S_MUL_HI   = 9'b000000100,
    S_MUL_LO   = 9'b000001000,
    S_WR_HI    = 9'b000010000,
    S_WR_LAST  = 9'b000100000,
    S_EMIT_RD  = 9'b001000000,
    S_EMIT_OUT = 9'b010000000,
    S_OVF      = 9'b100000000
  } state_t;

  state_t             state, state_next;
  order_t             order_count, order_count_next;
  logic signed [31:0] rc_reg;
  addr_t              cur_n;
  addr_t              pk;
  addr_t              ek;

  ram_ctrl_t  ram_ctrl;
  step_ctrl_t step_ctrl;
  word_t      wr_data;
  word_t      rd_a, rd_b;
  word_t      sum;

  addr_t  pj;
  order_t half;
  order_t n_eff;
  logic   middle;
  logic   last_pair;
  logic   in_xfer, out_xfer;

  assign in_xfer  = rc_ch.valid & rc_ch.ready;
  assign out_xfer = coef_ch.valid & coef_ch.ready;

  // Pair partner and loop bounds
  assign pj        = cur_n - pk - addr_t'(1);
  assign middle    = (pk == pj);
  assign half      = (order_t'(cur_n) + order_t'(1)) >> 1;
  assign last_pair = ((order_t'(pk) + order_t'(1)) == half);
  assign n_eff     = rc_ch.first_of_set ? '0 : order_count;

  // Store and unit controls
  always_comb begin
    ram_ctrl.rd_en     = (state == S_READ) || (state == S_EMIT_RD);
    ram_ctrl.rd_addr_a = (state == S_EMIT_RD) ? ek : pk;
    ram_ctrl.rd_addr_b = pj;
    ram_ctrl.wr_en     = (state == S_MUL_LO) || (state == S_WR_HI) || (state == S_WR_LAST);
    case (state)
      S_MUL_LO:  ram_ctrl.wr_addr = pk;
      S_WR_HI:   ram_ctrl.wr_addr = pj;
      default:   ram_ctrl.wr_addr = cur_n;
    endcase
    wr_data = (state == S_WR_LAST) ? rescale_rc(rc_reg) : sum;

    step_ctrl.mul_en    = (state == S_MUL_HI) || (state == S_MUL_LO);
    step_ctrl.mul_sel_a = (state == S_MUL_LO);
    step_ctrl.add_sel_a = (state == S_MUL_LO);
  end

  rtpc_coef_ram u_ram (
    .clk       (clk),
    .ctrl      (ram_ctrl),
    .wr_data   (wr_data),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  rtpc_step_unit u_step (
    .clk    (clk),
    .ctrl   (step_ctrl),
    .rc     (rc_reg),
    .data_a (rd_a),
    .data_b (rd_b),
    .sum    (sum)
  );

  // Sequencer next state
  always_comb begin
    state_next       = state;
    order_count_next = order_count;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (n_eff >= MAX_ORDER_C) begin
            state_next = S_OVF;
          end else begin
            order_count_next = n_eff;
            state_next       = (n_eff == '0) ? S_WR_LAST : S_READ;
          end
        end
      end
      S_READ:   state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_MUL_LO;
      S_MUL_LO: begin
        if (!middle) begin
          state_next = S_WR_HI;
        end else if (last_pair) begin
          state_next = S_WR_LAST;
        end else begin
          state_next = S_READ;
        end
      end
      S_WR_HI:  state_next = last_pair ? S_WR_LAST : S_READ;
      S_WR_LAST: begin
        order_count_next = order_t'(cur_n) + order_t'(1);
        state_next       = S_EMIT_RD;
      end
      S_EMIT_RD: state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_xfer) begin
          state_next = (ek == cur_n) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_OVF: begin
        if (out_xfer) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      order_count <= '0;
    end else begin
      state       <= state_next;
      order_count <= order_count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_xfer) begin
      rc_reg <= rc_ch.rc_value;
      cur_n  <= addr_t'(n_eff);
      pk     <= '0;
    end
    if ((state == S_MUL_LO && middle) || state == S_WR_HI) begin
      pk <= pk + addr_t'(1);
    end
    if (state == S_WR_LAST) begin
      ek <= '0;
    end else if (state == S_EMIT_OUT && out_xfer) begin
      ek <= ek + addr_t'(1);
    end
  end

  // Ports
  assign rc_ch.ready = (state == S_IDLE);

  assign coef_ch.valid          = (state == S_EMIT_OUT) || (state == S_OVF);
  assign coef_ch.coef_value     = (state == S_OVF) ? '0 : (word_t'(0) - rd_a);
  assign coef_ch.coef_index     = (state == S_OVF) ? '0 : ek;
  assign coef_ch.last_of_run    = (state == S_OVF) || (ek == cur_n);
  assign coef_ch.order_overflow = (state == S_OVF);

endmodule

`default_nettype wire

// ===== rtl/core/rtpc_coef_ram.sv =====
// ---------------------------------------------------------------------------
// rtpc_coef_ram
// Coefficient store: two registered read ports, one write port.
// ---------------------------------------------------------------------------
`default_nettype none

module rtpc_coef_ram
  import rtpc_pkg::*;
(
  input  wire             clk,
  input  wire ram_ctrl_t  ctrl,
  input  wire word_t      wr_data,
  output word_t           rd_data_a,
  output word_t           rd_data_b
);

  word_t mem [STORE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
  end

  // Read ports hold their data between reads
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_a <= mem[ctrl.rd_addr_a];
      rd_data_b <= mem[ctrl.rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rtpc_step_unit.sv =====
// ---------------------------------------------------------------------------
// rtpc_step_unit
// Shared multiply-round-add: registers rc * b, then a + round(p >> RC_FRAC_BITS).
// ---------------------------------------------------------------------------
`default_nettype none

module rtpc_step_unit
  import rtpc_pkg::*;
(
  input  wire                       clk,
  input  wire step_ctrl_t           ctrl,
  input  wire logic signed [31:0]   rc,
  input  wire word_t                data_a,
  input  wire word_t                data_b,
  output word_t                     sum
);

  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  word_t                    addend;

  assign mul_b  = ctrl.mul_sel_a ? data_a : data_b;
  assign addend = ctrl.add_sel_a ? data_a : data_b;

  // Full 64-bit signed product
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= rc * mul_b;
    end
  end

  // Round, shift (bit select), wrap-add
  assign rnd = prod + RND_ADD;
  assign sum = addend + rnd[RC_FRAC_BITS +: DATA_W];

endmodule

`default_nettype wire

// ===== dv/reflection_to_predictor_coefs_top_tb.sv =====
// ---------------------------------------------------------------------------
// reflection_to_predictor_coefs_top_tb
// Drives reflection coefficients into the step-up recursion block and checks
// every returned predictor coefficient against an in-bench recursion.
// Covers field extremes, odd/even orders, restarts, the full-order drop and
// long random sets, with random idle cycles on both channels.
// ---------------------------------------------------------------------------
module reflection_to_predictor_coefs_top_tb
  import rtpc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t      value;
    logic [5:0] index;
    logic       is_last;
    logic       overflow;
  } coef_result_t;

  logic clk = 1'b0;
  logic rst;
  logic no_idle = 1'b0;

  rtpc_in_if  rc_ch();
  rtpc_out_if coef_ch();

  reflection_to_predictor_coefs_top dut (
    .clk     (clk),
    .rst     (rst),
    .rc_ch   (rc_ch),
    .coef_ch (coef_ch)
  );

  // Bench copy of the recursion state
  word_t        lpc_coefs [STORE_DEPTH];
  order_t       lpc_order;
  coef_result_t pending_coefs [$];
  int           mismatches = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Mostly |rc| < 1.0, some full range, some corner values
  function automatic word_t draw_rc();
    word_t corners [8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                           32'h0000_0001, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000};
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return word_t'(int'($urandom_range(0, 2097150)) - 1048575);
    if (pick < 9) return word_t'($urandom());
    return corners[$urandom_range(0, 7)];
  endfunction

  // a + round(rc * b / 2^RC_FRAC_BITS), wrapped to 32 bits
  function automatic word_t step_up_term(word_t base, word_t rc, word_t other);
    longint prod;
    prod = longint'($signed(rc)) * longint'($signed(other));
    prod = prod + (longint'(1) <<< (RC_FRAC_BITS - 1));
    return word_t'(longint'($signed(base)) + (prod >>> RC_FRAC_BITS));
  endfunction

  // One recursion step; queues the coefficients it should produce
  function automatic void apply_reflection(word_t rc, logic restart);
    coef_result_t res;
    word_t        lo;
    word_t        hi;
    int           n;
    int           j;
    if (restart) lpc_order = '0;
    if (int'(lpc_order) >= MAX_ORDER || int'(lpc_order) >= STORE_DEPTH) begin
      // order full: input dropped, single flagged result
      res = '{value: '0, index: '0, is_last: 1'b1, overflow: 1'b1};
      pending_coefs.push_back(res);
      return;
    end
    n = int'(lpc_order);
    // both sides of a pair use the old values; middle element folds onto itself
    for (int k = 0; k < (n + 1) / 2; k++) begin
      j  = n - 1 - k;
      lo = lpc_coefs[k];
      hi = lpc_coefs[j];
      lpc_coefs[k] = step_up_term(lo, rc, hi);
      lpc_coefs[j] = step_up_term(hi, rc, lo);
    end
    if (COEF_FRAC_BITS > RC_FRAC_BITS) lpc_coefs[n] = rc << SHL_AMT;
    else lpc_coefs[n] = word_t'($signed(rc) >>> SHR_AMT);
    for (int k = 0; k <= n; k++) begin
      res = '{value: word_t'(0) - lpc_coefs[k], index: 6'(k),
              is_last: (k == n), overflow: 1'b0};
      pending_coefs.push_back(res);
    end
    lpc_order = order_t'(n + 1);
  endfunction

  // Predict on input transfers, check output transfers
  always @(posedge clk) begin
    coef_result_t exp_res;
    if (rst) begin
      lpc_order = '0;
    end else begin
      if (rc_ch.valid && rc_ch.ready) begin
        apply_reflection(rc_ch.rc_value, rc_ch.first_of_set);
      end
      if (coef_ch.valid && coef_ch.ready) begin
        if (pending_coefs.size() == 0) begin
          report_mismatch($sformatf("unexpected result idx=%0d value=%h",
                                    coef_ch.coef_index, coef_ch.coef_value));
        end else begin
          exp_res = pending_coefs.pop_front();
          if (coef_ch.coef_value !== exp_res.value)
            report_mismatch($sformatf("idx %0d: coef_value %h, expected %h",
                                      exp_res.index, coef_ch.coef_value, exp_res.value));
          if (coef_ch.coef_index !== exp_res.index)
            report_mismatch($sformatf("coef_index %0d, expected %0d",
                                      coef_ch.coef_index, exp_res.index));
          if (coef_ch.last_of_run !== exp_res.is_last)
            report_mismatch($sformatf("idx %0d: last_of_run %b, expected %b",
                                      exp_res.index, coef_ch.last_of_run, exp_res.is_last));
          if (coef_ch.order_overflow !== exp_res.overflow)
            report_mismatch($sformatf("idx %0d: order_overflow %b, expected %b",
                                      exp_res.index, coef_ch.order_overflow,
                                      exp_res.overflow));
        end
      end
    end
  end

  // Output side: random stall before each transfer
  initial begin
    int gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        coef_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      coef_ch.ready <= 1'b1;
      do @(posedge clk); while (!coef_ch.valid);
    end
  end

  // Valid stays high after the transfer; the next send or release_input sets it
  task automatic send_reflection(input word_t rc, input logic restart);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      rc_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rc_ch.valid        <= 1'b1;
    rc_ch.rc_value     <= rc;
    rc_ch.first_of_set <= restart;
    do @(posedge clk); while (!rc_ch.ready);
  endtask

  task automatic release_input();
    rc_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_coefs.size() != 0);
  endtask

  // Corner rc values across odd and even orders, then back-to-back restarts
  task automatic test_directed_corners();
    word_t rc_list [16] = '{32'h0008_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'h0000_0001, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000,
                            32'hFFF8_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFF7_FFFF, 32'h0007_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    no_idle = 1'b0;
    foreach (rc_list[i]) begin
      send_reflection(rc_list[i], (i == 0) || (i == 10) || (i == 11));
    end
    release_input();
    wait_drained();
  endtask

  // Fill to MAX_ORDER, push past it, then restart from a full order
  task automatic test_order_full();
    for (int pass = 0; pass < 2; pass++) begin
      no_idle = (pass == 1);
      for (int i = 0; i < MAX_ORDER; i++) begin
        send_reflection(draw_rc(), i == 0);
      end
      send_reflection(32'h7FFF_FFFF, 1'b0);
      send_reflection(32'h8000_0000, 1'b0);
      send_reflection(draw_rc(), 1'b0);
      send_reflection(32'h0004_0000, 1'b1);
      send_reflection(draw_rc(), 1'b0);
    end
    release_input();
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Random sets, mostly short, a few long enough to overflow; stray restarts
  task automatic test_random_sets(input int n_items);
    int   sent;
    int   set_len;
    logic restart;
    sent = 0;
    while (sent < n_items) begin
      no_idle = ($urandom_range(0, 3) == 0);
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      for (int i = 0; i < set_len; i++) begin
        restart = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        send_reflection(draw_rc(), restart);
        sent++;
      end
    end
    release_input();
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    rst                <= 1'b1;
    rc_ch.valid        <= 1'b0;
    rc_ch.rc_value     <= '0;
    rc_ch.first_of_set <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_order_full();
    test_random_sets(300);

    repeat (20) @(posedge clk);
    if (pending_coefs.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_coefs.size()));
    if (mismatches == 0) begin
      $display("PASS reflection_to_predictor_coefs_top");
    end else begin
      $display("FAIL reflection_to_predictor_coefs_top");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL reflection_to_predictor_coefs_top");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rtpc_pkg.sv
rtl/core/rtpc_in_if.sv
rtl/core/rtpc_out_if.sv
rtl/core/rtpc_coef_ram.sv
rtl/core/rtpc_step_unit.sv
rtl/core/reflection_to_predictor_coefs_top.sv
dv/reflection_to_predictor_coefs_top_tb.sv
